/* rtl/ipcf_pkg.sv */
`default_nettype none

package ipcf_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW = 1;
    localparam int unsigned Q_CW = 2;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;
    localparam logic [3:0] NO_RUN = 4'd8;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam logic [1:0] DEC_LAST_DIGIT = 2'd2;
    localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;
    localparam logic [2:0] V4_LAST_FIELD = 3'd3;
    localparam logic [2:0] V6_LAST_FIELD = 3'd7;

    typedef struct packed {
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic        family;
        logic        has_prefix;
        logic [7:0]  prefix_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_out_beat;

    typedef struct packed {
        logic [127:0] addr;
        logic         v6;
        logic         has_pfx;
        logic [7:0]   pfx;
        logic [3:0]   run_start;
        logic [3:0]   run_len;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_SEP,
        ST_DC1,
        ST_DC2,
        ST_SLASH,
        ST_PFX
    } t_state;

    function automatic logic [11:0] bcd8(input logic [7:0] v);
        logic [19:0] s;
        s = {12'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5) begin
                s[11:8] = s[11:8] + 4'd3;
            end
            if (s[15:12] >= 4'd5) begin
                s[15:12] = s[15:12] + 4'd3;
            end
            if (s[19:16] >= 4'd5) begin
                s[19:16] = s[19:16] + 4'd3;
            end
            s = s << 1;
        end
        return s[19:8];
    endfunction

    function automatic logic [1:0] dec_start(input logic [7:0] v);
        logic [1:0] r;
        if (v >= 8'd100) begin
            r = 2'd0;
        end else if (v >= 8'd10) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [1:0] hex_start(input logic [15:0] g);
        logic [1:0] r;
        if (g[15:12] != 4'd0) begin
            r = 2'd0;
        end else if (g[11:8] != 4'd0) begin
            r = 2'd1;
        end else if (g[7:4] != 4'd0) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'b0, nib};
        end else begin
            r = CH_LOWER_A + {4'b0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ipcf_front.sv */
`default_nettype none

module ipcf_front (
    input  wire ipcf_pkg::t_in_beat i_item,
    input  wire                     i_start,
    input  wire                     i_full,
    output logic                    o_push,
    output ipcf_pkg::t_entry        o_entry
);

    logic [7:0]   w_pfx;
    logic [127:0] w_mask;
    logic [127:0] w_addr;
    logic [7:0]   w_zero;
    logic [3:0]   w_cur_start;
    logic [3:0]   w_cur_len;
    logic [3:0]   w_win_start;
    logic [3:0]   w_win_len;

    assign o_push = i_start && !i_full;

    always_comb begin
        if (i_item.family) begin
            w_pfx = (i_item.prefix_length > ipcf_pkg::V6_MAX_PREFIX) ?
                    ipcf_pkg::V6_MAX_PREFIX : i_item.prefix_length;
        end else begin
            w_pfx = (i_item.prefix_length > ipcf_pkg::V4_MAX_PREFIX) ?
                    ipcf_pkg::V4_MAX_PREFIX : i_item.prefix_length;
        end
    end

    always_comb begin
        w_mask = i_item.has_prefix ? ~({128{1'b1}} >> w_pfx) : {128{1'b1}};
        w_addr = {i_item.address_high, i_item.address_low} & w_mask;
        if (!i_item.family) begin
            w_addr = {w_addr[127:96], 96'b0};
        end
    end

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            w_zero[g] = (w_addr[127 - 16 * g -: 16] == 16'd0);
        end
    end

    // The first of the longest zero runs wins because a later run must strictly exceed it.
    always_comb begin
        w_cur_start = 4'd0;
        w_cur_len = 4'd0;
        w_win_start = ipcf_pkg::NO_RUN;
        w_win_len = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (w_zero[i]) begin
                if (w_cur_len == 4'd0) begin
                    w_cur_start = 4'(i);
                end
                w_cur_len = w_cur_len + 4'd1;
                if (w_cur_len >= 4'd2 && w_cur_len > w_win_len) begin
                    w_win_start = w_cur_start;
                    w_win_len = w_cur_len;
                end
            end else begin
                w_cur_len = 4'd0;
            end
        end
    end

    always_comb begin
        o_entry.addr = w_addr;
        o_entry.v6 = i_item.family;
        o_entry.has_pfx = i_item.has_prefix;
        o_entry.pfx = w_pfx;
        o_entry.run_start = i_item.family ? w_win_start : ipcf_pkg::NO_RUN;
        o_entry.run_len = i_item.family ? w_win_len : 4'd0;
    end

endmodule

`default_nettype wire

/* rtl/ipcf_queue.sv */
`default_nettype none

module ipcf_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire ipcf_pkg::t_entry  i_entry,
    input  wire                    i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output ipcf_pkg::t_entry       o_head
);

    ipcf_pkg::t_entry r_mem [ipcf_pkg::Q_DEPTH];
    logic [ipcf_pkg::Q_AW-1:0] r_wp;
    logic [ipcf_pkg::Q_AW-1:0] r_rp;
    logic [ipcf_pkg::Q_CW-1:0] r_cnt;
    logic [ipcf_pkg::Q_AW-1:0] n_wp;
    logic [ipcf_pkg::Q_AW-1:0] n_rp;
    logic [ipcf_pkg::Q_CW-1:0] n_cnt;
    logic                      w_do_push;
    logic                      w_do_pop;

    assign o_full = (r_cnt == ipcf_pkg::Q_CW'(ipcf_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop = i_pop && o_valid;

    always_comb begin
        n_wp = w_do_push ? r_wp + 1'b1 : r_wp;
        n_rp = w_do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipcf_back.sv */
`default_nettype none

module ipcf_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire ipcf_pkg::t_entry  i_head,
    output logic                   o_pop,
    output logic                   o_strobe,
    output ipcf_pkg::t_out_beat    o_result
);

    ipcf_pkg::t_state    r_state;
    ipcf_pkg::t_state    n_state;
    ipcf_pkg::t_entry    r_cur;
    logic [2:0]          r_idx;
    logic [2:0]          n_idx;
    logic [1:0]          r_dig;
    logic [1:0]          n_dig;
    logic                r_strobe;
    logic                n_strobe;
    ipcf_pkg::t_out_beat r_out;
    ipcf_pkg::t_out_beat n_out;

    logic [15:0] w_group;
    logic [7:0]  w_dec_val;
    logic [11:0] w_bcd;
    logic [1:0]  w_first;
    logic [1:0]  w_eff;
    logic [3:0]  w_nib;
    logic        w_hex_mode;
    logic        w_end;
    logic [2:0]  w_idx_inc;
    logic [3:0]  w_after_run;

    assign w_group = r_cur.addr[127 - 16 * r_idx -: 16];
    assign w_hex_mode = r_cur.v6 && (r_state == ipcf_pkg::ST_NUM);
    assign w_dec_val = (r_state == ipcf_pkg::ST_PFX) ? r_cur.pfx :
                       r_cur.addr[127 - 8 * r_idx[1:0] -: 8];
    assign w_bcd = ipcf_pkg::bcd8(w_dec_val);
    assign w_first = w_hex_mode ? ipcf_pkg::hex_start(w_group) :
                     ipcf_pkg::dec_start(w_dec_val);
    assign w_eff = (r_dig < w_first) ? w_first : r_dig;
    assign w_nib = w_hex_mode ? w_group[15 - 4 * w_eff -: 4] : w_bcd[11 - 4 * w_eff -: 4];
    assign w_idx_inc = r_idx + 3'd1;
    assign w_after_run = {1'b0, r_idx} + r_cur.run_len;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_dig = r_dig;
        n_strobe = 1'b0;
        n_out.text_char = 8'd0;
        n_out.last_char = 1'b0;
        o_pop = 1'b0;
        w_end = 1'b0;
        case (r_state)
            ipcf_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_idx = 3'd0;
                    n_dig = 2'd0;
                    n_state = (i_head.v6 && i_head.run_start == 4'd0) ?
                              ipcf_pkg::ST_DC1 : ipcf_pkg::ST_NUM;
                end
            end
            ipcf_pkg::ST_NUM: begin
                n_strobe = 1'b1;
                n_out.text_char = ipcf_pkg::hex_char(w_nib);
                n_dig = w_eff + 2'd1;
                if (w_eff == (r_cur.v6 ? ipcf_pkg::HEX_LAST_DIGIT :
                                         ipcf_pkg::DEC_LAST_DIGIT)) begin
                    n_dig = 2'd0;
                    if (r_idx == (r_cur.v6 ? ipcf_pkg::V6_LAST_FIELD :
                                             ipcf_pkg::V4_LAST_FIELD)) begin
                        w_end = 1'b1;
                    end else begin
                        n_idx = w_idx_inc;
                        n_state = (r_cur.v6 && {1'b0, w_idx_inc} == r_cur.run_start) ?
                                  ipcf_pkg::ST_DC1 : ipcf_pkg::ST_SEP;
                    end
                end
            end
            ipcf_pkg::ST_SEP: begin
                n_strobe = 1'b1;
                n_out.text_char = r_cur.v6 ? ipcf_pkg::CH_COLON : ipcf_pkg::CH_DOT;
                n_state = ipcf_pkg::ST_NUM;
            end
            ipcf_pkg::ST_DC1: begin
                n_strobe = 1'b1;
                n_out.text_char = ipcf_pkg::CH_COLON;
                n_state = ipcf_pkg::ST_DC2;
            end
            ipcf_pkg::ST_DC2: begin
                n_strobe = 1'b1;
                n_out.text_char = ipcf_pkg::CH_COLON;
                if (w_after_run[3]) begin
                    w_end = 1'b1;
                end else begin
                    n_idx = w_after_run[2:0];
                    n_dig = 2'd0;
                    n_state = ipcf_pkg::ST_NUM;
                end
            end
            ipcf_pkg::ST_SLASH: begin
                n_strobe = 1'b1;
                n_out.text_char = ipcf_pkg::CH_SLASH;
                n_dig = 2'd0;
                n_state = ipcf_pkg::ST_PFX;
            end
            ipcf_pkg::ST_PFX: begin
                n_strobe = 1'b1;
                n_out.text_char = ipcf_pkg::hex_char(w_nib);
                n_dig = w_eff + 2'd1;
                if (w_eff == ipcf_pkg::DEC_LAST_DIGIT) begin
                    n_out.last_char = 1'b1;
                    n_state = ipcf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ipcf_pkg::ST_IDLE;
            end
        endcase
        if (w_end) begin
            if (r_cur.has_pfx) begin
                n_state = ipcf_pkg::ST_SLASH;
            end else begin
                n_out.last_char = 1'b1;
                n_state = ipcf_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipcf_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_dig <= n_dig;
        r_out <= n_out;
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* rtl/ip_prefix_canonical_formatter_top.sv */
// With the sequencer idle, an accepted beat is written into the queue, popped into the
// sequencer's current-entry register, and its first character is then registered onto the
// result ports. The sequencer pops an entry only from idle and does not pop another until it
// has put out the last character. The longest text has 43 characters; the two-entry queue takes two more beats
// before busy rises. The receiver cannot stall: each character is shown for one cycle.
// Synchronous active-low reset empties the queue, idles the sequencer and clears the strobe.
`default_nettype none

module ip_prefix_canonical_formatter_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire ipcf_pkg::t_in_beat i_item,
    output logic                    o_strobe,
    output ipcf_pkg::t_out_beat     o_result
);

    logic             w_push;
    logic             w_full;
    logic             w_valid;
    logic             w_pop;
    ipcf_pkg::t_entry w_entry;
    ipcf_pkg::t_entry w_head;

    assign busy = w_full;

    ipcf_front u_front (
        .i_item  (i_item),
        .i_start (start),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    ipcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_head  (w_head)
    );

    ipcf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* test/ip_prefix_canonical_formatter_top_test.sv */
`timescale 1ns / 1ps

module ip_prefix_canonical_formatter_top_test;
    import ipcf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam logic FAMILY_V4 = 1'b0;
    localparam logic FAMILY_V6 = 1'b1;
    localparam logic [63:0] ALL_ONES = '1;
    localparam string HEX_DIGITS = "0123456789abcdef";
    localparam string FULL_V6 = "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff";

    typedef struct {
        t_in_beat beat;
        string    text;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_item;
    logic      o_strobe;
    t_out_beat o_result;

    t_row        rows[$];
    logic [7:0]  text_buf[$];
    t_out_beat   pending_text[$];
    int          typed_row;
    int          burst_left;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned chars_seen;
    int unsigned v4_count;
    int unsigned v6_count;
    int unsigned prefixed_count;

    ip_prefix_canonical_formatter_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d characters outstanding.",
                     cycle_count, pending_text.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic logic [63:0] keep_top(input int unsigned bits);
        if (bits == 0) begin
            return '0;
        end
        if (bits >= 64) begin
            return ALL_ONES;
        end
        return ALL_ONES << (64 - bits);
    endfunction

    function automatic void put_decimal(input int unsigned v);
        if (v >= 100) begin
            text_buf.push_back(CH_ZERO + 8'((v / 100) % 10));
        end
        if (v >= 10) begin
            text_buf.push_back(CH_ZERO + 8'((v / 10) % 10));
        end
        text_buf.push_back(CH_ZERO + 8'(v % 10));
    endfunction

    function automatic void put_hex(input logic [15:0] g);
        logic started;
        started = 1'b0;
        for (int s = 12; s >= 0; s -= 4) begin
            logic [3:0] nib;
            nib = g[s +: 4];
            if (nib != 0 || started || s == 0) begin
                text_buf.push_back(HEX_DIGITS[nib]);
                started = 1'b1;
            end
        end
    endfunction

    function automatic void predict_text(input t_in_beat b);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] groups[8];
        int unsigned pfx;
        int unsigned win_start;
        int unsigned win_len;
        int unsigned run_from;
        int unsigned i;
        hi = b.address_high;
        lo = b.address_low;
        pfx = b.prefix_length;
        if (b.family == FAMILY_V6) begin
            if (pfx > 128) begin
                pfx = 128;
            end
        end else if (pfx > 32) begin
            pfx = 32;
        end
        if (b.has_prefix) begin
            hi &= keep_top(pfx);
            lo &= keep_top(pfx > 64 ? pfx - 64 : 0);
        end
        if (b.family == FAMILY_V4) begin
            for (i = 0; i < 4; i++) begin
                if (i != 0) begin
                    text_buf.push_back(CH_DOT);
                end
                put_decimal(hi[56 - 8 * i +: 8]);
            end
        end else begin
            for (i = 0; i < 4; i++) begin
                groups[i] = hi[48 - 16 * i +: 16];
                groups[i + 4] = lo[48 - 16 * i +: 16];
            end
            win_start = 8;
            win_len = 0;
            i = 0;
            while (i < 8) begin
                if (groups[i] != 0) begin
                    i++;
                    continue;
                end
                run_from = i;
                while (i < 8 && groups[i] == 0) begin
                    i++;
                end
                if (i - run_from >= 2 && i - run_from > win_len) begin
                    win_start = run_from;
                    win_len = i - run_from;
                end
            end
            i = 0;
            while (i < 8) begin
                if (i == win_start) begin
                    text_buf.push_back(CH_COLON);
                    text_buf.push_back(CH_COLON);
                    i += win_len;
                    continue;
                end
                if (i != 0 && i != win_start + win_len) begin
                    text_buf.push_back(CH_COLON);
                end
                put_hex(groups[i]);
                i++;
            end
        end
        if (b.has_prefix) begin
            text_buf.push_back(CH_SLASH);
            put_decimal(pfx);
        end
    endfunction

    function automatic void commit_text();
        t_out_beat c;
        foreach (text_buf[k]) begin
            c.text_char = text_buf[k];
            c.last_char = (k == text_buf.size() - 1);
            pending_text.push_back(c);
        end
        text_buf.delete();
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && start && !busy) begin
            if (typed_row >= 0) begin
                for (int k = 0; k < rows[typed_row].text.len(); k++) begin
                    text_buf.push_back(rows[typed_row].text[k]);
                end
            end else begin
                predict_text(i_item);
            end
            commit_text();
            if (i_item.family == FAMILY_V6) begin
                v6_count++;
            end else begin
                v4_count++;
            end
            if (i_item.has_prefix) begin
                prefixed_count++;
            end
        end
        if (i_rst_n && o_strobe) begin
            chars_seen++;
            if (pending_text.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          o_result.text_char, o_result.last_char));
            end else begin
                want = pending_text.pop_front();
                if (o_result.text_char !== want.text_char) begin
                    report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                              o_result.text_char, want.text_char));
                end
                if (o_result.last_char !== want.last_char) begin
                    report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                              o_result.last_char, want.last_char,
                                              want.text_char));
                end
            end
        end
    end

    function automatic void add_row(input logic [63:0] hi, input logic [63:0] lo,
                                    input logic fam, input logic pfx_on,
                                    input logic [7:0] pfx, input string text);
        t_row r;
        r.beat.address_high = hi;
        r.beat.address_low = lo;
        r.beat.family = fam;
        r.beat.has_prefix = pfx_on;
        r.beat.prefix_length = pfx;
        r.text = text;
        rows.push_back(r);
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        logic [15:0] g;
        b.family = ($urandom_range(0, 3) != 0) ? FAMILY_V6 : FAMILY_V4;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 4))
                0, 1: g = '0;
                2: g = 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
                3: g = 16'hFFFF;
                default: g = 16'($urandom);
            endcase
            if (k < 4) begin
                b.address_high[48 - 16 * k +: 16] = g;
            end else begin
                b.address_low[48 - 16 * (k - 4) +: 16] = g;
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            b.address_high = {$urandom, $urandom};
            b.address_low = {$urandom, $urandom};
        end
        b.has_prefix = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            b.prefix_length = 8'($urandom_range(0, 255));
        end else begin
            b.prefix_length = 8'($urandom_range(0, b.family == FAMILY_V6 ? 129 : 33));
        end
        return b;
    endfunction

    task automatic drive_beat(input t_in_beat b, input int row);
        start <= 1'b1;
        i_item <= b;
        typed_row <= row;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 6);
        gap = $urandom_range(1, 10);
        start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_text.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        typed_row = -1;
        burst_left = 0;
        mismatches = 0;
        chars_seen = 0;
        v4_count = 0;
        v6_count = 0;
        prefixed_count = 0;

        add_row('0, '0, FAMILY_V4, 1'b0, 8'd0, "0.0.0.0");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V4, 1'b0, 8'd255, "255.255.255.255");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V4, 1'b1, 8'd255, "255.255.255.255/32");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V4, 1'b1, 8'd33, "255.255.255.255/32");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V4, 1'b1, 8'd0, "0.0.0.0/0");
        add_row(64'hC0A8_014D_0000_0000, '0, FAMILY_V4, 1'b1, 8'd24, "192.168.1.0/24");
        add_row(64'h0A00_0001_FFFF_FFFF, ALL_ONES, FAMILY_V4, 1'b0, 8'd0, "10.0.0.1");
        add_row(64'h6463_0A09_0000_0000, '0, FAMILY_V4, 1'b0, 8'd0, "100.99.10.9");
        add_row('0, '0, FAMILY_V6, 1'b0, 8'd0, "::");
        add_row('0, '0, FAMILY_V6, 1'b1, 8'd0, "::/0");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b0, 8'd0, FULL_V6);
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd128, {FULL_V6, "/128"});
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd255, {FULL_V6, "/128"});
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd129, {FULL_V6, "/128"});
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd127,
                "ffff:ffff:ffff:ffff:ffff:ffff:ffff:fffe/127");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd64, "ffff:ffff:ffff:ffff::/64");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd65, "ffff:ffff:ffff:ffff:8000::/65");
        add_row(ALL_ONES, ALL_ONES, FAMILY_V6, 1'b1, 8'd0, "::/0");
        add_row('0, 64'd1, FAMILY_V6, 1'b0, 8'd0, "::1");
        add_row(64'h0001_0000_0000_0000, '0, FAMILY_V6, 1'b0, 8'd0, "1::");
        add_row(64'h0001_0000_0001_0001, 64'h0001_0001_0001_0001, FAMILY_V6, 1'b0, 8'd0,
                "1:0:1:1:1:1:1:1");
        add_row(64'h0001_0000_0000_0001, 64'h0000_0000_0001_0001, FAMILY_V6, 1'b0, 8'd0,
                "1::1:0:0:1:1");
        add_row(64'h0001_0000_0000_0001, 64'h0000_0000_0000_0001, FAMILY_V6, 1'b0, 8'd0,
                "1:0:0:1::1");
        add_row(64'h0ABC_00D0_000F_1234, 64'h2001_0DB8_0000_0000, FAMILY_V6, 1'b0, 8'd0, "");
        add_row(64'h2001_0DB8_85A3_0000, 64'h0000_8A2E_0370_7334, FAMILY_V6, 1'b1, 8'd48, "");

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            drive_beat(rows[k].beat, rows[k].text.len() != 0 ? k : -1);
            pace();
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            drive_beat(random_beat(), -1);
            pace();
        end
        wait_drained();

        $display("Checked %0d addresses (%0d IPv4, %0d IPv6, %0d prefixed), %0d characters,",
                 v4_count + v6_count, v4_count, v6_count, prefixed_count, chars_seen);
        $display("covering clamped prefixes, zero-run compression and bursts; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
